FILE: rtl/core/rbf_pkg.sv
// Shared types, codes and constants of the RGB brightness fade engine.
package rbf_pkg;

    localparam int TIME_BITS_DEFAULT = 16;

    localparam int CFG_WIDTH    = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam int CHAN_W       = 7;
    localparam int BRIGHT_W     = 8;
    localparam int SPAN_W       = 16;
    localparam int PROD_W       = BRIGHT_W + SPAN_W;
    localparam int QUOT_W       = BRIGHT_W;

    localparam logic [CFG_WIDTH-1:0] DURATION_RESET = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] STEP_RESET     = 16'd16;
    localparam logic [CHAN_W-1:0]    COLOUR_MASK    = 7'h7f;
    localparam logic [BRIGHT_W-1:0]  BRIGHT_FULL    = 8'h80;

    // Register indices of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_FADE_DURATION = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_INTERVAL = 1'd1;

    // Operation codes of an input item.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_COLOUR = 2'd1;
    localparam logic [1:0] OP_BRIGHT = 2'd2;

    // Channel numbers walked by the sequencer; brightness is the last one.
    localparam logic [1:0] CH_RED    = 2'd0;
    localparam logic [1:0] CH_GREEN  = 2'd1;
    localparam logic [1:0] CH_BLUE   = 2'd2;
    localparam logic [1:0] CH_BRIGHT = 2'd3;

    localparam logic [2:0] DIV_LAST_STEP = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_APPLY,
        ST_SCALE,
        ST_SCALE_WR,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_mdu_ctl;

endpackage

FILE: rtl/core/rbf_if.sv
// Handshake channels for input items and result items.
interface rbf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;

    modport source (output valid, operation, red, green, blue, level, input ready);
    modport sink   (input valid, operation, red, green, blue, level, output ready);
endinterface

interface rbf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_red;
    logic [6:0] out_green;
    logic [6:0] out_blue;
    logic       fade_done;

    modport source (output valid, out_red, out_green, out_blue, fade_done, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, fade_done, output ready);
endinterface

FILE: rtl/core/rbf_muldiv.sv
// Shared 8x16 multiplier with a bit-serial restoring divider behind it.
module rbf_muldiv (
    input  logic                         i_clk,
    input  rbf_pkg::t_mdu_ctl            i_ctl,
    input  logic [rbf_pkg::BRIGHT_W-1:0] i_mul_a,
    input  logic [rbf_pkg::SPAN_W-1:0]   i_mul_b,
    input  logic [rbf_pkg::SPAN_W-1:0]   i_divisor,
    output logic [rbf_pkg::PROD_W-1:0]   o_prod,
    output logic [rbf_pkg::QUOT_W-1:0]   o_quot
);
    logic [rbf_pkg::SPAN_W-1:0]   r_hi;
    logic [rbf_pkg::QUOT_W-1:0]   r_lo;
    logic [rbf_pkg::PROD_W-1:0]   w_prod;
    logic [rbf_pkg::SPAN_W:0]     w_trial;
    logic [rbf_pkg::SPAN_W:0]     w_sub;
    logic                         w_ge;

    assign w_prod  = rbf_pkg::PROD_W'(i_mul_a) * rbf_pkg::PROD_W'(i_mul_b);

    // The quotient is known to fit in eight bits, so the upper part of the
    // product already lies below the divisor and only eight steps remain.
    assign w_trial = {r_hi, r_lo[rbf_pkg::QUOT_W-1]};
    assign w_sub   = w_trial - {1'b0, i_divisor};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hi <= w_prod[rbf_pkg::PROD_W-1:rbf_pkg::QUOT_W];
            r_lo <= w_prod[rbf_pkg::QUOT_W-1:0];
        end else if (i_ctl.step) begin
            r_hi <= w_ge ? w_sub[rbf_pkg::SPAN_W-1:0] : w_trial[rbf_pkg::SPAN_W-1:0];
            r_lo <= {r_lo[rbf_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_prod = {r_hi, r_lo};
    assign o_quot = r_lo;

endmodule

FILE: rtl/core/rgb_brightness_fade_engine.sv
// Top level of the RGB brightness fade engine: sequencer, fade state and result register.
//
//  Channel   Direction  Handshake          Payload
//  i_item    in         valid / ready      operation, red, green, blue, level
//  o_result  out        valid / ready      out_red, out_green, out_blue, fade_done
//  i_cfg_*   in         write enable only  index, 16-bit data
//
// A set command or an ignored item is handled in the idle state, and a tick short of the next
// step mark returns to idle after the check. A tick that ends a fade goes straight to scaling;
// one that makes an intermediate step first runs each of the four channels through a multiply,
// eight divide steps and an apply step in the shared unit. Each drive value then takes a
// multiply and a write in the same multiplier. Input is not ready while a tick is worked on;
// a finished item holds the sequencer only while the previous result has not been taken. Reset is synchronous.
module rgb_brightness_fade_engine #(
    parameter int TIME_BITS = rbf_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rbf_in_if.sink                           i_item,
    rbf_out_if.source                        o_result,
    input  logic                             i_cfg_we,
    input  logic [rbf_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [rbf_pkg::CFG_WIDTH-1:0]    i_cfg_data
);
    localparam int MW = TIME_BITS + 1;
    localparam int CW = (TIME_BITS > rbf_pkg::SPAN_W) ? TIME_BITS : rbf_pkg::SPAN_W;
    localparam int AW = ((MW > rbf_pkg::SPAN_W) ? MW : rbf_pkg::SPAN_W) + 1;

    rbf_pkg::t_state r_state, n_state;

    logic [rbf_pkg::CFG_WIDTH-1:0] r_fade_duration;
    logic [rbf_pkg::CFG_WIDTH-1:0] r_step_interval;

    logic [rbf_pkg::CHAN_W-1:0]   r_start_rgb   [3];
    logic [rbf_pkg::CHAN_W-1:0]   r_target_rgb  [3];
    logic [rbf_pkg::CHAN_W-1:0]   r_current_rgb [3];
    logic [rbf_pkg::BRIGHT_W-1:0] r_start_bright;
    logic [rbf_pkg::BRIGHT_W-1:0] r_target_bright;
    logic [rbf_pkg::BRIGHT_W-1:0] r_current_bright;
    logic [TIME_BITS-1:0]         r_elapsed;
    logic [MW-1:0]                r_next_mark;
    logic                         r_fading;

    logic [1:0]                 r_idx;
    logic [2:0]                 r_cnt;
    logic                       r_done;
    logic [rbf_pkg::CHAN_W-1:0] r_res [3];

    logic                       r_out_valid;
    logic [rbf_pkg::CHAN_W-1:0] r_out_red;
    logic [rbf_pkg::CHAN_W-1:0] r_out_green;
    logic [rbf_pkg::CHAN_W-1:0] r_out_blue;
    logic                       r_out_done;

    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_reached;
    logic                         w_past_mark;
    logic [rbf_pkg::SPAN_W-1:0]   w_e16;
    logic [rbf_pkg::BRIGHT_W-1:0] w_s;
    logic [rbf_pkg::BRIGHT_W-1:0] w_t;
    logic                         w_up;
    logic [rbf_pkg::BRIGHT_W-1:0] w_diff;
    logic [rbf_pkg::BRIGHT_W-1:0] w_new;
    logic [rbf_pkg::CHAN_W-1:0]   w_cur;

    rbf_pkg::t_mdu_ctl            w_ctl;
    logic [rbf_pkg::BRIGHT_W-1:0] w_mul_a;
    logic [rbf_pkg::SPAN_W-1:0]   w_mul_b;
    logic [rbf_pkg::PROD_W-1:0]   w_prod;
    logic [rbf_pkg::QUOT_W-1:0]   w_quot;

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    assign w_reached   = (CW'(r_elapsed) >= CW'(r_fade_duration));
    assign w_past_mark = (MW'(r_elapsed) > r_next_mark);

    // Below the duration the elapsed count always fits the divider's span.
    generate
        if (TIME_BITS >= rbf_pkg::SPAN_W) begin : g_span_cut
            assign w_e16 = r_elapsed[rbf_pkg::SPAN_W-1:0];
        end else begin : g_span_ext
            assign w_e16 = {{(rbf_pkg::SPAN_W - TIME_BITS){1'b0}}, r_elapsed};
        end
    endgenerate

    always_comb begin
        case (r_idx)
            rbf_pkg::CH_RED: begin
                w_s   = {1'b0, r_start_rgb[0]};
                w_t   = {1'b0, r_target_rgb[0]};
                w_cur = r_current_rgb[0];
            end
            rbf_pkg::CH_GREEN: begin
                w_s   = {1'b0, r_start_rgb[1]};
                w_t   = {1'b0, r_target_rgb[1]};
                w_cur = r_current_rgb[1];
            end
            rbf_pkg::CH_BLUE: begin
                w_s   = {1'b0, r_start_rgb[2]};
                w_t   = {1'b0, r_target_rgb[2]};
                w_cur = r_current_rgb[2];
            end
            default: begin
                w_s   = r_start_bright;
                w_t   = r_target_bright;
                w_cur = r_current_rgb[0];
            end
        endcase
    end

    assign w_up   = (w_t >= w_s);
    assign w_diff = w_up ? (w_t - w_s) : (w_s - w_t);
    assign w_new  = w_up ? (w_s + w_quot) : (w_s - w_quot);

    rbf_muldiv u_muldiv (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_mul_a   (w_mul_a),
        .i_mul_b   (w_mul_b),
        .i_divisor (r_fade_duration),
        .o_prod    (w_prod),
        .o_quot    (w_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rbf_pkg::ST_IDLE: begin
                if (w_accept && i_item.operation == rbf_pkg::OP_TICK && r_fading) begin
                    n_state = rbf_pkg::ST_CHECK;
                end
            end
            rbf_pkg::ST_CHECK: begin
                if (w_reached) begin
                    n_state = rbf_pkg::ST_SCALE;
                end else if (w_past_mark) begin
                    n_state = rbf_pkg::ST_MUL;
                end else begin
                    n_state = rbf_pkg::ST_IDLE;
                end
            end
            rbf_pkg::ST_MUL: begin
                n_state = rbf_pkg::ST_DIV;
            end
            rbf_pkg::ST_DIV: begin
                if (r_cnt == rbf_pkg::DIV_LAST_STEP) begin
                    n_state = rbf_pkg::ST_APPLY;
                end
            end
            rbf_pkg::ST_APPLY: begin
                n_state = (r_idx == rbf_pkg::CH_BRIGHT) ? rbf_pkg::ST_SCALE : rbf_pkg::ST_MUL;
            end
            rbf_pkg::ST_SCALE: begin
                n_state = rbf_pkg::ST_SCALE_WR;
            end
            rbf_pkg::ST_SCALE_WR: begin
                n_state = (r_idx == rbf_pkg::CH_BLUE) ? rbf_pkg::ST_PUSH : rbf_pkg::ST_SCALE;
            end
            rbf_pkg::ST_PUSH: begin
                if (w_out_free) begin
                    n_state = rbf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rbf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        i_item.ready = 1'b0;
        w_ctl        = '0;
        w_mul_a      = w_diff;
        w_mul_b      = w_e16;
        case (r_state)
            rbf_pkg::ST_IDLE: begin
                i_item.ready = 1'b1;
            end
            rbf_pkg::ST_MUL: begin
                w_ctl.load = 1'b1;
            end
            rbf_pkg::ST_DIV: begin
                w_ctl.step = 1'b1;
            end
            rbf_pkg::ST_SCALE: begin
                w_ctl.load = 1'b1;
                w_mul_a    = {1'b0, w_cur};
                w_mul_b    = {{(rbf_pkg::SPAN_W - rbf_pkg::BRIGHT_W){1'b0}}, r_current_bright};
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= rbf_pkg::ST_IDLE;
            r_fade_duration  <= rbf_pkg::DURATION_RESET;
            r_step_interval  <= rbf_pkg::STEP_RESET;
            r_start_rgb      <= '{default: '0};
            r_target_rgb     <= '{default: '0};
            r_current_rgb    <= '{default: '0};
            r_start_bright   <= '0;
            r_target_bright  <= '0;
            r_current_bright <= '0;
            r_elapsed        <= '0;
            r_next_mark      <= '0;
            r_fading         <= 1'b0;
            r_idx            <= '0;
            r_cnt            <= '0;
            r_done           <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == rbf_pkg::REG_FADE_DURATION) begin
                    r_fade_duration <= i_cfg_data;
                end else if (i_cfg_idx == rbf_pkg::REG_STEP_INTERVAL) begin
                    r_step_interval <= i_cfg_data;
                end
            end

            if (r_state == rbf_pkg::ST_PUSH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                rbf_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        if (i_item.operation == rbf_pkg::OP_COLOUR ||
                            i_item.operation == rbf_pkg::OP_BRIGHT) begin
                            r_start_rgb    <= r_current_rgb;
                            r_start_bright <= r_current_bright;
                            r_elapsed      <= '0;
                            r_next_mark    <= MW'(r_step_interval);
                            r_fading       <= 1'b1;
                        end
                        if (i_item.operation == rbf_pkg::OP_COLOUR) begin
                            r_target_rgb[0] <= i_item.red[rbf_pkg::CHAN_W-1:0] & rbf_pkg::COLOUR_MASK;
                            r_target_rgb[1] <= i_item.green[rbf_pkg::CHAN_W-1:0] & rbf_pkg::COLOUR_MASK;
                            r_target_rgb[2] <= i_item.blue[rbf_pkg::CHAN_W-1:0] & rbf_pkg::COLOUR_MASK;
                            r_target_bright <= rbf_pkg::BRIGHT_FULL;
                        end else if (i_item.operation == rbf_pkg::OP_BRIGHT) begin
                            r_target_bright <= {1'b0, i_item.level[rbf_pkg::CHAN_W-1:0]} + 8'd1;
                        end else if (i_item.operation == rbf_pkg::OP_TICK && r_fading) begin
                            if (r_elapsed != {TIME_BITS{1'b1}}) begin
                                r_elapsed <= r_elapsed + TIME_BITS'(1);
                            end
                        end
                    end
                end
                rbf_pkg::ST_CHECK: begin
                    r_idx <= rbf_pkg::CH_RED;
                    if (w_reached) begin
                        r_fading         <= 1'b0;
                        r_current_rgb    <= r_target_rgb;
                        r_current_bright <= r_target_bright;
                        r_done           <= 1'b1;
                    end else if (w_past_mark) begin
                        r_next_mark <= MW'(AW'(r_next_mark) + AW'(r_step_interval));
                        r_done      <= 1'b0;
                    end
                end
                rbf_pkg::ST_MUL: begin
                    r_cnt <= '0;
                end
                rbf_pkg::ST_DIV: begin
                    r_cnt <= r_cnt + 3'd1;
                end
                rbf_pkg::ST_APPLY: begin
                    case (r_idx)
                        rbf_pkg::CH_RED:   r_current_rgb[0] <= w_new[rbf_pkg::CHAN_W-1:0];
                        rbf_pkg::CH_GREEN: r_current_rgb[1] <= w_new[rbf_pkg::CHAN_W-1:0];
                        rbf_pkg::CH_BLUE:  r_current_rgb[2] <= w_new[rbf_pkg::CHAN_W-1:0];
                        default:           r_current_bright <= w_new;
                    endcase
                    r_idx <= r_idx + 2'd1;
                end
                rbf_pkg::ST_SCALE_WR: begin
                    // Drive value is bits 13..7 of colour times brightness.
                    case (r_idx)
                        rbf_pkg::CH_RED:   r_res[0] <= w_prod[13:7];
                        rbf_pkg::CH_GREEN: r_res[1] <= w_prod[13:7];
                        default:           r_res[2] <= w_prod[13:7];
                    endcase
                    r_idx <= r_idx + 2'd1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // Result payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == rbf_pkg::ST_PUSH && w_out_free) begin
            r_out_red   <= r_res[0];
            r_out_green <= r_res[1];
            r_out_blue  <= r_res[2];
            r_out_done  <= r_done;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.out_red   = r_out_red;
    assign o_result.out_green = r_out_green;
    assign o_result.out_blue  = r_out_blue;
    assign o_result.fade_done = r_out_done;

    // A new result only ever appears from the hand-over state.
    a_result_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == rbf_pkg::ST_PUSH))
        else $error("result appeared outside the hand-over state");

    // An accepted tick during a fade must start the step check.
    a_tick_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.operation == rbf_pkg::OP_TICK && r_fading)
        |=> (r_state == rbf_pkg::ST_CHECK))
        else $error("tick during a fade was not processed");

    // Interpolation only runs while a fade is in progress.
    a_div_while_fading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbf_pkg::ST_DIV) |-> r_fading)
        else $error("divider running outside a fade");

    // The interpolated step can never overshoot the span between start and target.
    a_quot_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbf_pkg::ST_APPLY) |-> (w_quot <= w_diff))
        else $error("interpolation quotient exceeds channel span");

endmodule
